/* hdl/pmcd_pkg.sv */
// Shared types, constants and character tables for the POCSAG message character decoder.
package pmcd_pkg;

    localparam int MAX_CHARS_DEF  = 128;
    localparam int WORD_W         = 20;
    localparam int CHAR_W         = 7;
    localparam int IDX_W          = 7;
    localparam int TYPE_W         = 2;
    localparam int CHARS_PER_WORD = 5;
    localparam int CNT_W          = 3;
    localparam int SLOT_W         = 3;
    localparam int NIB_W          = 4;
    localparam int JOB_DEPTH      = 2;
    localparam int EXT_W          = CHARS_PER_WORD * CHAR_W;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;
    localparam logic [CHAR_W-1:0] CH_U     = 7'h55;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 7'h29;
    localparam logic [CHAR_W-1:0] CH_LPAR  = 7'h28;

    typedef enum logic [TYPE_W-1:0] {
        MT_NUMERIC = 2'd0,
        MT_SKIP_A  = 2'd1,
        MT_SKIP_B  = 2'd2,
        MT_ALPHA   = 2'd3
    } t_msg_type;

    // One request from the front to the back: up to five characters to emit.
    typedef struct packed {
        logic                                   numeric;
        logic [CNT_W-1:0]                       count;
        logic [CHARS_PER_WORD-1:0][CHAR_W-1:0]  data;
        logic [IDX_W-1:0]                       base;
    } t_job;

    function automatic logic [CHAR_W-1:0] numeric_char(input logic [NIB_W-1:0] nib);
        logic [CHAR_W-1:0] ch;
        ch = CH_ZERO;
        unique case (nib)
            4'hA:    ch = CH_STAR;
            4'hB:    ch = CH_U;
            4'hC:    ch = CH_SPACE;
            4'hD:    ch = CH_DASH;
            4'hE:    ch = CH_RPAR;
            4'hF:    ch = CH_LPAR;
            default: ch = CH_ZERO + {3'b000, nib};
        endcase
        return ch;
    endfunction

endpackage

/* hdl/pmcd_front.sv */
// Front end: accepts payload words, keeps the message position and builds character requests.
module pmcd_front
    import pmcd_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TYPE_W-1:0] i_cfg_wdata,
    input  logic              i_take,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_start_req,
    output logic              o_enq,
    output t_job              o_job
);

    localparam int ALPHA_LIMIT = MAX_CHARS * CHAR_W;
    localparam int POS_W       = $clog2(ALPHA_LIMIT + WORD_W + 1);

    t_msg_type         r_msg_type;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0]  r_quot, n_quot;
    logic [CHAR_W-1:0] r_partial, n_partial;

    logic [POS_W-1:0]  pos_eff;
    logic [SLOT_W-1:0] slot_eff;
    logic [IDX_W-1:0]  quot_eff;
    logic [CHAR_W-1:0] partial_eff;
    logic [WORD_W-1:0] rev;
    logic [EXT_W-1:0]  ext;
    logic              alpha_ok;
    logic              num_ok;
    t_job              job;

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            rev[i] = i_word[WORD_W-1-i];
        end
    end

    assign pos_eff     = i_start_req ? '0 : r_pos;
    assign slot_eff    = i_start_req ? '0 : r_slot;
    assign quot_eff    = i_start_req ? '0 : r_quot;
    assign partial_eff = i_start_req ? '0 : r_partial;

    // Bit stream with the pending bits first, then the word's bits in arrival order.
    assign ext      = EXT_W'(partial_eff) | (EXT_W'(rev) << slot_eff);
    assign alpha_ok = (pos_eff + POS_W'(WORD_W)) < POS_W'(ALPHA_LIMIT);
    assign num_ok   = (pos_eff + POS_W'(CHARS_PER_WORD)) < POS_W'(MAX_CHARS);

    always_comb begin
        n_pos     = pos_eff;
        n_slot    = slot_eff;
        n_quot    = quot_eff;
        n_partial = partial_eff;
        o_enq     = 1'b0;
        job       = '0;
        if (r_msg_type == MT_ALPHA && alpha_ok) begin
            o_enq       = 1'b1;
            job.numeric = 1'b0;
            job.data    = ext;
            job.base    = quot_eff;
            n_pos       = pos_eff + POS_W'(WORD_W);
            if (slot_eff == '0) begin
                job.count = CNT_W'(2);
                n_partial = ext[2*CHAR_W +: CHAR_W];
                n_slot    = SLOT_W'(CHAR_W - 1);
                n_quot    = quot_eff + IDX_W'(2);
            end else begin
                job.count = CNT_W'(3);
                n_partial = ext[3*CHAR_W +: CHAR_W];
                n_slot    = slot_eff - SLOT_W'(1);
                n_quot    = quot_eff + IDX_W'(3);
            end
        end else if (r_msg_type == MT_NUMERIC && num_ok) begin
            o_enq       = 1'b1;
            job.numeric = 1'b1;
            job.count   = CNT_W'(CHARS_PER_WORD);
            job.base    = pos_eff[IDX_W-1:0];
            for (int k = 0; k < CHARS_PER_WORD; k++) begin
                // Nibble k sits in bits of the word's k-th group from the top, reversed.
                for (int b = 0; b < NIB_W; b++) begin
                    job.data[k][b] = i_word[(CHARS_PER_WORD-1-k)*NIB_W + (NIB_W-1-b)];
                end
            end
            n_pos = pos_eff + POS_W'(CHARS_PER_WORD);
            if (slot_eff >= SLOT_W'(2)) begin
                n_slot = slot_eff - SLOT_W'(2);
                n_quot = quot_eff + IDX_W'(1);
            end else begin
                n_slot = slot_eff + SLOT_W'(CHARS_PER_WORD);
            end
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_type <= MT_NUMERIC;
            r_pos      <= '0;
            r_slot     <= '0;
            r_quot     <= '0;
            r_partial  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_msg_type <= t_msg_type'(i_cfg_wdata);
            end
            if (i_take) begin
                r_pos     <= n_pos;
                r_slot    <= n_slot;
                r_quot    <= n_quot;
                r_partial <= n_partial;
            end
        end
    end

endmodule

/* hdl/pmcd_queue.sv */
// Short request queue between the front end and the character output stage.
module pmcd_queue
    import pmcd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_enq,
    input  t_job i_job,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head,
    input  logic i_deq
);

    localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_QW = $clog2(JOB_DEPTH + 1);

    t_job               r_mem [JOB_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_QW-1:0]  r_cnt;
    logic               do_enq;
    logic               do_deq;

    assign o_full       = (r_cnt == CNT_QW'(JOB_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign do_enq       = i_enq && !o_full;
    assign do_deq       = i_deq && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_enq) begin
                r_wr <= (r_wr == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_deq) begin
                r_rd <= (r_rd == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_enq && !do_deq) begin
                r_cnt <= r_cnt + CNT_QW'(1);
            end else if (do_deq && !do_enq) begin
                r_cnt <= r_cnt - CNT_QW'(1);
            end
        end
    end

endmodule

/* hdl/pmcd_back.sv */
// Back end: walks one request character by character into the output register.
module pmcd_back
    import pmcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  t_job              i_head,
    output logic              o_deq,
    input  logic              pop,
    output logic              empty,
    output logic [CHAR_W-1:0] o_char_code,
    output logic [IDX_W-1:0]  o_char_index,
    output logic              o_last
);

    logic [CNT_W-1:0]  r_k;
    logic              r_valid;
    logic [CHAR_W-1:0] r_code;
    logic [IDX_W-1:0]  r_index;
    logic              r_last;
    logic              load;
    logic              is_last;
    logic [CHAR_W-1:0] raw;
    logic [CHAR_W-1:0] code;

    assign load    = i_head_valid && (!r_valid || pop);
    assign is_last = (r_k == i_head.count - CNT_W'(1));
    assign raw     = i_head.data[r_k];
    assign code    = i_head.numeric ? numeric_char(raw[NIB_W-1:0]) : raw;
    assign o_deq   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code  <= code;
            r_index <= i_head.base + IDX_W'(r_k);
            r_last  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= is_last ? '0 : r_k + CNT_W'(1);
            end else if (pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign empty        = !r_valid;
    assign o_char_code  = r_code;
    assign o_char_index = r_index;
    assign o_last       = r_last;

endmodule

/* hdl/pocsag_message_char_decoder.sv */
// With the output stage idle, the first character of a word is written into the request queue
// at the edge that accepts its push and is loaded into the output register in the cycle after.
// Throughput: one character per cycle from the output stage while pop is held; a word
// yields two, three or five characters (alphanumeric or numeric), or none and no request.
// The figure is set by the single output register fed from a two-entry request queue.
// Reset (synchronous, active low) clears the position, partial character, queue and output
// and sets the message type to numeric; no clearing pass is needed.
module pocsag_message_char_decoder
    import pmcd_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TYPE_W-1:0] i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_start_req,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] o_char_code,
    output logic [IDX_W-1:0]  o_char_index,
    output logic              o_last
);

    // A word is taken whenever the request queue has room. The front end updates the
    // message position in the same cycle and, when the word produces characters,
    // writes one request into the queue.
    logic w_take;
    logic w_enq;
    t_job w_job;
    logic w_head_valid;
    t_job w_head;
    logic w_deq;

    assign w_take = push && !full;

    pmcd_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_word      (i_word),
        .i_start_req (i_start_req),
        .o_enq       (w_enq),
        .o_job       (w_job)
    );

    // The queue decouples word intake from character output, so a new word can be
    // accepted while the previous one is still being emitted.
    pmcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enq        (w_take && w_enq),
        .i_job        (w_job),
        .o_full       (full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_deq        (w_deq)
    );

    // The back end emits one character per cycle while pop is held and retires the request on its
    // final character, which it marks with o_last.
    pmcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_deq        (w_deq),
        .pop          (pop),
        .empty        (empty),
        .o_char_code  (o_char_code),
        .o_char_index (o_char_index),
        .o_last       (o_last)
    );

    // Every request carries two, three or five characters.
    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_enq) |-> (w_job.count == CNT_W'(2) || w_job.count == CNT_W'(3) ||
                               w_job.count == CNT_W'(CHARS_PER_WORD)))
        else $error("request with an impossible character count");

    // Within one word the next character follows at once with the next index.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=>
            (!empty && o_char_index == IDX_W'($past(o_char_index) + IDX_W'(1))))
        else $error("character index did not advance within a word");

    // Nothing is shown on the result side right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

    // The queue is never retired from while it holds nothing.
    a_deq_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deq |-> w_head_valid)
        else $error("request retired from an empty queue");

endmodule
